// ===== design/itoa_pkg.sv =====
// itoa_pkg: shared types, constants and helpers for the integer to ascii formatter
// no dependencies; imported by itoa_dabble and integer_to_ascii_formatter_top
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

  // fixed field widths
  localparam int VALUE_W    = 32;
  localparam int OPCODE_W   = 2;
  localparam int CHAR_W     = 8;
  localparam int IN_DATA_W  = 40;  // value + opcode, padded to whole bytes
  localparam int OUT_DATA_W = 8;

  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_UDEC = 2'd0,
    OP_SDEC = 2'd1,
    OP_OCT  = 2'd2,
    OP_HEX  = 2'd3
  } op_t;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // number of decimal digits needed for a w-bit unsigned word
  function automatic int dec_digits(input int w);
    return (w * 30103) / 100000 + 1;
  endfunction

  // uppercase hex digit character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_UPPER_A + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/integer_to_ascii_formatter_top.sv =====
// integer_to_ascii_formatter_top: formats one word per item as ascii characters
// depends on itoa_pkg and itoa_dabble
`timescale 1ns / 1ps
`default_nettype none

// Each input item carries a word and a format code (unsigned decimal, signed
// decimal, octal with a leading '0', hex with "0x" and uppercase digits) and
// produces a run of characters, most significant digit first, with tlast on
// the final one. Decimal runs end in a space; octal and hex of zero give only
// the prefix. One item is handled at a time. Decimal formats first run the
// bit-serial binary to bcd shift loop, then step through the minus sign if
// there is one, the digit positions and the closing space. Octal and hex
// skip the conversion and step through their prefix characters and digit
// positions. The steps go one per cycle, but a step waits while the output
// side holds tready low and a character is still waiting. A new item is
// taken once the last character of the previous one has been moved into the
// output register.
module integer_to_ascii_formatter_top #(
  parameter int WORD_BITS = itoa_pkg::WORD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: value [31:0], opcode [33:32], zero padding [39:34]
  input  wire logic [itoa_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // out_tdata: char_out [7:0]
  output logic [itoa_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                   out_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready
);
  import itoa_pkg::*;

  localparam int DecDigits = dec_digits(WORD_BITS);
  localparam int HexDigits = (WORD_BITS + 3) / 4;
  localparam int OctDigits = (WORD_BITS + 2) / 3;
  localparam int EmW0      = (DecDigits * 4 > HexDigits * 4) ? DecDigits * 4 : HexDigits * 4;
  localparam int EmW       = (EmW0 > OctDigits * 3) ? EmW0 : OctDigits * 3;
  localparam int CntMax0   = (DecDigits > OctDigits) ? DecDigits : OctDigits;
  localparam int CntMax    = (CntMax0 > HexDigits) ? CntMax0 : HexDigits;
  localparam int DcntW     = $clog2(CntMax + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_PFX  = 5'b00100,
    ST_DIG  = 5'b01000,
    ST_SPC  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic                 neg_r, neg_nxt;
  logic                 zero_r, zero_nxt;
  logic                 pfx_r, pfx_nxt;
  logic                 seen_r, seen_nxt;
  logic [EmW-1:0]       em_r, em_nxt;
  logic [DcntW-1:0]     dcnt_r, dcnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [WORD_BITS-1:0] in_word;
  op_t                  in_op;
  logic                 in_neg;
  logic                 accept;
  logic                 slot_free;
  logic                 conv_start;
  logic [WORD_BITS-1:0] conv_word;
  logic                 conv_done;
  logic [DecDigits*4-1:0] conv_bcd;
  logic [3:0]           dig;
  logic                 final_dig;
  logic                 pfx_last;

  assign in_word   = WORD_BITS'(in_tdata[VALUE_W-1:0]);
  assign in_op     = op_t'(in_tdata[VALUE_W +: OPCODE_W]);
  assign in_neg    = (in_op == OP_SDEC) && in_word[WORD_BITS-1];
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  assign conv_start = accept && (in_op == OP_UDEC || in_op == OP_SDEC);
  assign conv_word  = in_neg ? (~in_word + WORD_BITS'(1)) : in_word;

  itoa_dabble #(
    .WORD_BITS (WORD_BITS)
  ) u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .word  (conv_word),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  // top digit of the emission shift register
  assign dig       = (op_r == OP_OCT) ? {1'b0, em_r[EmW-1 -: 3]} : em_r[EmW-1 -: 4];
  assign final_dig = (dcnt_r == DcntW'(1));
  assign pfx_last  = zero_r && (op_r == OP_OCT || (op_r == OP_HEX && pfx_r));

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    neg_nxt       = neg_r;
    zero_nxt      = zero_r;
    pfx_nxt       = pfx_r;
    seen_nxt      = seen_r;
    em_nxt        = em_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt   = in_op;
          neg_nxt  = in_neg;
          zero_nxt = (in_word == '0);
          pfx_nxt  = 1'b0;
          seen_nxt = 1'b0;
          if (in_op == OP_HEX) begin
            em_nxt    = EmW'(in_word) << (EmW - HexDigits * 4);
            dcnt_nxt  = DcntW'(HexDigits);
            state_nxt = ST_PFX;
          end else if (in_op == OP_OCT) begin
            em_nxt    = EmW'(in_word) << (EmW - OctDigits * 3);
            dcnt_nxt  = DcntW'(OctDigits);
            state_nxt = ST_PFX;
          end else begin
            state_nxt = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          em_nxt    = EmW'(conv_bcd) << (EmW - DecDigits * 4);
          dcnt_nxt  = DcntW'(DecDigits);
          state_nxt = neg_r ? ST_PFX : ST_DIG;
        end
      end
      ST_PFX: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = pfx_last;
          unique case (op_r)
            OP_HEX:  out_char_nxt = pfx_r ? CH_X : CH_ZERO;
            OP_OCT:  out_char_nxt = CH_ZERO;
            default: out_char_nxt = CH_MINUS;
          endcase
          if (op_r == OP_HEX && !pfx_r) begin
            pfx_nxt = 1'b1;
          end else if (pfx_last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_DIG;
          end
        end
      end
      ST_DIG: begin
        if (slot_free) begin
          // leading zeros are skipped, the units digit always goes out
          if (seen_r || dig != 4'd0 || final_dig) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = digit_char(dig);
            out_last_nxt  = final_dig && (op_r == OP_OCT || op_r == OP_HEX);
          end
          seen_nxt = seen_r || (dig != 4'd0);
          em_nxt   = (op_r == OP_OCT) ? (em_r << 3) : (em_r << 4);
          dcnt_nxt = dcnt_r - DcntW'(1);
          if (final_dig) begin
            state_nxt = (op_r == OP_OCT || op_r == OP_HEX) ? ST_IDLE : ST_SPC;
          end
        end
      end
      ST_SPC: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_SPACE;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    neg_r      <= neg_nxt;
    zero_r     <= zero_nxt;
    pfx_r      <= pfx_nxt;
    seen_r     <= seen_nxt;
    em_r       <= em_nxt;
    dcnt_r     <= dcnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== design/itoa_dabble.sv =====
// itoa_dabble: bit-serial binary to bcd converter (shift and add-3), one bit per cycle
// depends on itoa_pkg
`timescale 1ns / 1ps
`default_nettype none

module itoa_dabble #(
  parameter int WORD_BITS = itoa_pkg::WORD_BITS_DEF
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          start,
  input  wire logic [WORD_BITS-1:0]                          word,
  output logic                                               done,
  output logic [itoa_pkg::dec_digits(WORD_BITS)*4-1:0]       bcd
);
  import itoa_pkg::*;

  localparam int DecDigits = dec_digits(WORD_BITS);
  localparam int BcdW      = DecDigits * 4;
  localparam int CntW      = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] bin_r, bin_nxt;
  logic [BcdW-1:0]      bcd_r, bcd_nxt, adj;
  logic [CntW-1:0]      cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;

  // add 3 to every digit that is 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3 : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done     = 1'b0;
    if (start) begin
      bin_nxt  = word;
      bcd_nxt  = '0;
      cnt_nxt  = CntW'(WORD_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        done     = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        bcd_nxt = {adj[BcdW-2:0], bin_r[WORD_BITS-1]};
        bin_nxt = {bin_r[WORD_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign bcd = bcd_r;

endmodule

`default_nettype wire
